/* src/jump_consistent_hash_bucket_assert.svh */
// Assertion macros for the jump consistent hash bucket checker.
// Included by the checker module; no other dependencies.
`ifndef JUMP_CONSISTENT_HASH_BUCKET_ASSERT_SVH
`define JUMP_CONSISTENT_HASH_BUCKET_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JCHB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jchb same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define JCHB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jchb next-cycle check failed");

`endif

/* src/jchb_pkg.sv */
// Shared types and constants for the jump consistent hash bucket block.
// Used by the controller, datapath and top level; no dependencies.
`default_nettype none

package jchb_pkg;

    localparam int KEY_W         = 64;
    localparam int HALF_W        = 32;
    localparam int DIVISOR_W     = 32;
    localparam int JUMP_SHIFT    = 31;
    localparam int KEY_TOP_SHIFT = 33;

    localparam logic [KEY_W-1:0]  LCG_MULT    = 64'h27BB_2EE6_87B0_B0FD;
    localparam logic [HALF_W-1:0] LCG_MULT_LO = LCG_MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0] LCG_MULT_HI = LCG_MULT[KEY_W-1:HALF_W];

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_DIV_INIT,
        S_DIV,
        S_CHECK
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_MUL3,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_ADVANCE,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic jump_below;
    } t_dp_status;

endpackage

`default_nettype wire

/* src/jchb_ctrl.sv */
// Controller state machine for the jump consistent hash bucket block.
// Depends on jchb_pkg; drives the datapath through t_dp_cmd.
`default_nettype none

module jchb_ctrl #(
    parameter int BUCKET_BITS = 31
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire                  i_stall,
    output jchb_pkg::t_dp_cmd    o_cmd,
    input  jchb_pkg::t_dp_status i_status
);
    import jchb_pkg::*;

    localparam int DIV_STEPS = (BUCKET_BITS + JUMP_SHIFT + 2) / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        o_cmd.op    = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.op = DP_MUL0;
                n_state  = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.op = DP_MUL1;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.op = DP_MUL2;
                n_state  = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.op = DP_MUL3;
                n_state  = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.op = DP_DIV_INIT;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = DP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.jump_below) begin
                    // take the jump as the new candidate, run another round
                    o_cmd.op = DP_ADVANCE;
                    n_state  = S_MUL0;
                end else if (!r_out_valid || !i_stall) begin
                    o_cmd.op    = DP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

/* src/jchb_dp.sv */
// Datapath for the jump consistent hash bucket block: key LCG on a shared
// 32x32 multiplier, radix-2 restoring divider (two bits a cycle), count register.
// Depends on jchb_pkg; commanded by jchb_ctrl.
`default_nettype none

module jchb_dp #(
    parameter int BUCKET_BITS = 31
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  jchb_pkg::t_dp_cmd            i_cmd,
    output jchb_pkg::t_dp_status         o_status,
    input  wire [jchb_pkg::KEY_W-1:0]    i_key,
    input  wire                          i_cfg_we,
    input  wire [BUCKET_BITS-1:0]        i_cfg_data,
    output logic [BUCKET_BITS-1:0]       o_bucket
);
    import jchb_pkg::*;

    localparam int DIV_STEPS = (BUCKET_BITS + JUMP_SHIFT + 2) / 2;
    localparam int QW        = 2 * DIV_STEPS;

    logic [BUCKET_BITS-1:0] r_count;
    logic [BUCKET_BITS-1:0] w_eff_count;

    logic [KEY_W-1:0]       r_key;
    logic [KEY_W-1:0]       r_acc;
    logic [KEY_W-1:0]       r_prod;
    logic [BUCKET_BITS-1:0] r_cand;
    logic [BUCKET_BITS-1:0] r_bucket;
    logic [DIVISOR_W-1:0]   r_div;
    logic [DIVISOR_W-1:0]   r_rem;
    logic [QW-1:0]          r_quo;

    logic [HALF_W-1:0]      w_mul_a, w_mul_b;
    logic [KEY_W-1:0]       w_prod;
    logic [KEY_W-1:0]       w_cross;
    logic [BUCKET_BITS:0]   w_cand_inc;
    logic [QW-1:0]          w_dividend;
    logic [DIVISOR_W-1:0]   w_rem_next;
    logic [QW-1:0]          w_quo_next;

    // Bucket count register; zero acts as one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= BUCKET_BITS'(1);
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    assign w_eff_count = (r_count == '0) ? BUCKET_BITS'(1) : r_count;

    // Shared multiplier: low 64 bits of key * LCG_MULT + 1 from three partial products.
    always_comb begin
        case (i_cmd.op)
            DP_MUL1: begin
                w_mul_a = r_key[HALF_W-1:0];
                w_mul_b = LCG_MULT_HI;
            end
            DP_MUL2: begin
                w_mul_a = r_key[KEY_W-1:HALF_W];
                w_mul_b = LCG_MULT_LO;
            end
            default: begin
                w_mul_a = r_key[HALF_W-1:0];
                w_mul_b = LCG_MULT_LO;
            end
        endcase
    end

    assign w_prod  = w_mul_a * w_mul_b;
    assign w_cross = {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};

    assign w_cand_inc = {1'b0, r_cand} + 1'b1;
    assign w_dividend = QW'(w_cand_inc) << JUMP_SHIFT;

    // Two restoring division steps per cycle.
    always_comb begin
        logic [DIVISOR_W:0] t;
        logic               qbit;
        w_rem_next = r_rem;
        w_quo_next = r_quo;
        for (int s = 0; s < 2; s++) begin
            t    = {w_rem_next, w_quo_next[QW-1]};
            qbit = (t >= {1'b0, r_div});
            if (qbit) begin
                w_rem_next = DIVISOR_W'(t - {1'b0, r_div});
            end else begin
                w_rem_next = t[DIVISOR_W-1:0];
            end
            w_quo_next = {w_quo_next[QW-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_key  <= i_key;
                r_cand <= '0;
            end
            DP_MUL0: begin
                r_prod <= w_prod;
            end
            DP_MUL1: begin
                r_acc  <= r_prod + KEY_W'(1);
                r_prod <= w_prod;
            end
            DP_MUL2: begin
                r_acc  <= r_acc + w_cross;
                r_prod <= w_prod;
            end
            DP_MUL3: begin
                r_key <= r_acc + w_cross;
            end
            DP_DIV_INIT: begin
                r_div <= DIVISOR_W'(r_key[KEY_W-1:KEY_TOP_SHIFT]) + DIVISOR_W'(1);
                r_rem <= '0;
                r_quo <= w_dividend;
            end
            DP_DIV_STEP: begin
                r_rem <= w_rem_next;
                r_quo <= w_quo_next;
            end
            DP_ADVANCE: begin
                r_cand <= r_quo[BUCKET_BITS-1:0];
            end
            DP_OUT: begin
                r_bucket <= r_cand;
            end
            default: begin
            end
        endcase
    end

    assign o_status.jump_below = (r_quo < QW'(w_eff_count));
    assign o_bucket            = r_bucket;

endmodule

`default_nettype wire

/* src/jump_consistent_hash_bucket.sv */
// Top level of the jump consistent hash bucket block.
// Instantiates jchb_ctrl and jchb_dp; depends on jchb_pkg.
//
// Input channel (i_valid, o_stall, i_key): a key transfers on a rising edge with
// i_valid high and o_stall low. One key at a time: o_stall is high from the
// cycle after the transfer until the key's bucket is loaded for output.
// Output channel (o_valid, i_stall, o_bucket): one bucket per key, held in an
// output register until it transfers (i_stall low). A new key may be taken
// while a finished bucket still waits there.
// Config channel (i_cfg_valid, o_cfg_ready, i_cfg_data): writes bucket_count;
// o_cfg_ready is always high. Write only while the block is idle. A count of
// zero acts as one.
// Rounds: a round runs the LCG step in states S_MUL0 to S_MUL3 on one shared
// 32x32 multiplier, then a divider setup, the divider's two-bits-a-cycle
// iterations and a compare. A key runs R rounds, R about ln(bucket_count) + 1.
// When the output is free, o_valid rises in the cycle after the last compare and
// the next key can transfer in that same cycle, not before the last key is done.
// A stalled receiver holds the last compare until the output register empties.
// Reset (i_rst_n low, synchronous): drops any key in flight and any pending
// bucket, and sets bucket_count to 1.
`default_nettype none

module jump_consistent_hash_bucket #(
    parameter int BUCKET_BITS = 31
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire [jchb_pkg::KEY_W-1:0]    i_key,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [BUCKET_BITS-1:0]       o_bucket,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [BUCKET_BITS-1:0]        i_cfg_data
);
    import jchb_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_cfg_we;

    // Config writes are always accepted; the count register sits in the datapath.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    jchb_ctrl #(
        .BUCKET_BITS (BUCKET_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    jchb_dp #(
        .BUCKET_BITS (BUCKET_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_key      (i_key),
        .i_cfg_we   (w_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_bucket   (o_bucket)
    );

endmodule

`default_nettype wire

/* src/jchb_checker.sv */
// Port-level checker for the jump consistent hash bucket block, with its bind.
// Depends on jump_consistent_hash_bucket_assert.svh and jchb_pkg.
`default_nettype none
`include "jump_consistent_hash_bucket_assert.svh"

module jchb_checker #(
    parameter int BUCKET_BITS = 31
) (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_valid,
    input wire                       o_stall,
    input wire [jchb_pkg::KEY_W-1:0] i_key,
    input wire                       o_valid,
    input wire                       i_stall,
    input wire [BUCKET_BITS-1:0]     o_bucket,
    input wire                       i_cfg_valid,
    input wire                       o_cfg_ready,
    input wire [BUCKET_BITS-1:0]     i_cfg_data
);
    import jchb_pkg::*;

    logic [BUCKET_BITS-1:0] r_count;
    logic [BUCKET_BITS-1:0] w_eff_count;
    logic                   w_in_xfer;

    // Track the bucket count from config transfers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= BUCKET_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= i_cfg_data;
        end
    end

    assign w_eff_count = (r_count == '0) ? BUCKET_BITS'(1) : r_count;
    assign w_in_xfer   = i_valid && !o_stall;

    `JCHB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_bucket))
    `JCHB_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(i_key))
    `JCHB_ASSERT_NOW(a_bucket_range, i_clk, i_rst_n, o_valid, o_bucket < w_eff_count)
    `JCHB_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, w_in_xfer, o_stall)
    `JCHB_ASSERT_NOW(a_busy_cause, i_clk, i_rst_n, $rose(o_stall), $past(w_in_xfer))

endmodule

bind jump_consistent_hash_bucket jchb_checker #(
    .BUCKET_BITS (BUCKET_BITS)
) u_jchb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_key       (i_key),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_bucket    (o_bucket),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire

/* bench/tb_jump_consistent_hash_bucket.sv */
// Self-checking bench for jump_consistent_hash_bucket: keys, bucket counts and buckets.
// Needs jchb_pkg and the block's RTL; predicts each bucket with its own jump hash loop.
`default_nettype none

module tb_jump_consistent_hash_bucket;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUCKET_BITS = 31;
    localparam int KEY_W       = jchb_pkg::KEY_W;

    // LCG step applied to the key once per round, modulo 2^64
    localparam logic [63:0] KEY_STEP_MULT = 64'd2862933555777941757;
    localparam logic [BUCKET_BITS-1:0] COUNT_MAX = {BUCKET_BITS{1'b1}};

    // Receiver behavior between long holds
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic                   o_stall;
    logic [KEY_W-1:0]       i_key       = '0;
    logic                   o_valid;
    logic                   i_stall     = 1'b0;
    logic [BUCKET_BITS-1:0] o_bucket;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [BUCKET_BITS-1:0] i_cfg_data  = '0;

    jump_consistent_hash_bucket #(
        .BUCKET_BITS (BUCKET_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_key       (i_key),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_bucket    (o_bucket),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Keys waiting to be offered, and buckets owed by the block in transfer order
    logic [KEY_W-1:0]       key_queue[$];
    logic [BUCKET_BITS-1:0] predicted_buckets[$];

    // Bucket count the block holds now; changed only while the block is idle
    logic [BUCKET_BITS-1:0] bucket_count_mirror = BUCKET_BITS'(1);

    int error_count = 0;
    int keys_sent   = 0;
    int rx_count    = 0;
    int cfg_writes  = 0;
    int long_holds  = 0;

    // Append a key at the tail of the pending queue
    function automatic void enqueue_key(input logic [KEY_W-1:0] key);
        key_queue.insert(key_queue.size(), key);
    endfunction

    // Jump consistent hash: keep the last jump as candidate, step the key, and
    // compute the next jump as an exact quotient until it reaches the count.
    function automatic logic [BUCKET_BITS-1:0] jump_bucket(
        input logic [63:0]            key,
        input logic [BUCKET_BITS-1:0] count
    );
        logic [63:0] k;
        logic [63:0] cand;
        logic [63:0] jump;
        logic [63:0] divisor;
        logic [63:0] limit;
        k     = key;
        cand  = 64'd0;
        jump  = 64'd0;
        // a zero count behaves as one bucket
        limit = (count == '0) ? 64'd1 : 64'(count);
        while (jump < limit) begin
            cand    = jump;
            k       = k * KEY_STEP_MULT + 64'd1;
            divisor = (k >> 33) + 64'd1;
            jump    = ((cand + 64'd1) << 31) / divisor;
        end
        return cand[BUCKET_BITS-1:0];
    endfunction

    // Uniform keys half the time, corner patterns the other half
    function automatic logic [63:0] random_key();
        logic [63:0] one_hot;
        one_hot = 64'd1 << $urandom_range(0, 63);
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            4:       return 64'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Driver: offer keys in bursts separated by random gaps. Hold the key and
    // valid until the transfer, then predict its bucket with the current count.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : drive_keys
        logic offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            offer = i_valid;
            if (i_valid && !o_stall) begin
                predicted_buckets.insert(predicted_buckets.size(),
                                         jump_bucket(i_key, bucket_count_mirror));
                keys_sent++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (key_queue.size() != 0) begin
                    offer = 1'b1;
                    i_key <= key_queue.pop_front();
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        // start a new burst; gaps span short, mid-round and multi-round idles
                        burst_left = $urandom_range(0, 24);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(1, 8);
                            2:       gap_left = $urandom_range(9, 120);
                            default: gap_left = $urandom_range(121, 900);
                        endcase
                    end
                end
            end
            // one assignment per edge: a held valid is never dropped and re-raised
            i_valid <= offer;
        end
    end

    // Monitor: compare every bucket transfer with the oldest prediction, and
    // drive i_stall from randomly chosen stall modes and occasional long holds.
    t_stall_mode stall_mode  = STALL_NONE;
    int          mode_left   = 0;
    int          hold_left   = 0;
    int          cycle_count = 0;

    always @(posedge i_clk) begin : check_buckets
        logic [BUCKET_BITS-1:0] want;
        logic                   stall_next;
        cycle_count++;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                rx_count++;
                if (predicted_buckets.size() == 0) begin
                    $error("bucket: no result expected, actual %0d", o_bucket);
                    error_count++;
                end else begin
                    want = predicted_buckets.pop_front();
                    if (o_bucket !== want) begin
                        $error("bucket: expected %0d, actual %0d", want, o_bucket);
                        error_count++;
                    end
                end
            end

            if (hold_left != 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (long_holds < 2 && o_valid && i_valid &&
                         rx_count >= ((long_holds == 0) ? 40 : 480)) begin
                // hold off long enough that the block parks a bucket, takes the
                // next key, and then stalls its input while keys keep coming
                hold_left  = 2500;
                long_holds++;
                stall_next = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = t_stall_mode'($urandom_range(0, 3));
                    mode_left  = $urandom_range(20, 400);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    STALL_NONE:     stall_next = 1'b0;
                    STALL_COIN:     stall_next = 1'($urandom_range(0, 1));
                    STALL_HEAVY:    stall_next = ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: stall_next = cycle_count[2];
                    default:        stall_next = 1'b0;
                endcase
            end
            i_stall <= stall_next;
        end
    end

    // Wait until every key has transferred and every bucket has come back;
    // check again after the settle time in case a key was just taken off the queue
    task automatic wait_idle();
        do begin
            do @(posedge i_clk);
            while (key_queue.size() != 0 || i_valid || predicted_buckets.size() != 0);
            repeat (8) @(posedge i_clk);
        end while (key_queue.size() != 0 || i_valid || predicted_buckets.size() != 0);
    endtask

    // Write bucket_count through the config channel; call only while idle
    task automatic write_bucket_count(input logic [BUCKET_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        bucket_count_mirror = value;
        cfg_writes++;
    endtask

    // Queue n keys in two halves and drain in between, so the sender also
    // pauses until the block has returned everything
    task automatic hash_random_keys(input int n);
        for (int i = 0; i < n / 2; i++) enqueue_key(random_key());
        wait_idle();
        for (int i = n / 2; i < n; i++) enqueue_key(random_key());
        wait_idle();
    endtask

    initial begin : stimulus
        logic [BUCKET_BITS-1:0] count;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset count of one: every key lands in bucket 0
        enqueue_key(64'd0);
        enqueue_key('1);
        enqueue_key(64'h8000_0000_0000_0000);
        enqueue_key(64'd1);
        wait_idle();

        // Full-range count: the most rounds per key
        write_bucket_count(COUNT_MAX);
        enqueue_key(64'd0);
        enqueue_key('1);
        enqueue_key(64'd1);
        enqueue_key(64'h8000_0000_0000_0000);
        enqueue_key(64'h5555_5555_5555_5555);
        enqueue_key(64'hAAAA_AAAA_AAAA_AAAA);
        enqueue_key(64'h0000_0001_0000_0000);
        enqueue_key(64'h0000_0000_FFFF_FFFF);
        enqueue_key(64'h0123_4567_89AB_CDEF);
        wait_idle();

        // Zero count acts as one bucket
        write_bucket_count('0);
        enqueue_key(64'd0);
        enqueue_key('1);
        enqueue_key(64'h5555_5555_5555_5555);
        wait_idle();

        // Two buckets, then a count just past the top bit
        write_bucket_count(BUCKET_BITS'(2));
        enqueue_key(64'd0);
        enqueue_key('1);
        enqueue_key(64'hAAAA_AAAA_AAAA_AAAA);
        enqueue_key(64'd1);
        wait_idle();
        write_bucket_count(31'h4000_0001);
        enqueue_key(64'hFFFF_FFFF_0000_0000);
        enqueue_key(64'h0000_0000_FFFF_FFFF);
        wait_idle();

        // Random keys under a spread of counts, from zero and one up to full range
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       count = BUCKET_BITS'($urandom_range(2, 16));
                1:       count = '0;
                2:       count = COUNT_MAX;
                3:       count = BUCKET_BITS'($urandom_range(1, 1000));
                4:       count = BUCKET_BITS'($urandom);
                5:       count = BUCKET_BITS'(1);
                6:       count = BUCKET_BITS'($urandom_range(1000, 1000000));
                default: count = 31'h4000_0000;
            endcase
            write_bucket_count(count);
            hash_random_keys(103);
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (predicted_buckets.size() != 0) begin
            $error("bucket: %0d results never arrived", predicted_buckets.size());
            error_count++;
        end

        $display("Summary: %0d keys hashed across %0d bucket-count writes, zero and full range",
                 keys_sent, cfg_writes);
        $display("included; %0d buckets compared, %0d long receiver holds.",
                 rx_count, long_holds);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Timeout far beyond the slowest correct run
    initial begin : watchdog
        #100_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
